FILE: hw/rtl/smabc_pkg.sv
// Shared types and constants for the six-axis moving-average filter with gyro bias calibration.
// Holds the sample and result transaction structs, the command codes and the default sizes.
// No dependencies.
`default_nettype none

package smabc_pkg;

	localparam int NCH    = 6;
	localparam int NGYRO  = 3;
	localparam int DATA_W = 16;

	localparam int WINDOW_DEF         = 10;
	localparam int CAL_SAMPLES_DEF    = 100;
	localparam int SETTLE_SAMPLES_DEF = 100;

	typedef enum logic {
		FUNC_SAMPLE = 1'b0,
		FUNC_CAL    = 1'b1
	} func_t;

	typedef struct packed {
		func_t              func;
		logic signed [15:0] gyro_x_raw;
		logic signed [15:0] gyro_y_raw;
		logic signed [15:0] gyro_z_raw;
		logic signed [15:0] accel_x_raw;
		logic signed [15:0] accel_y_raw;
		logic signed [15:0] accel_z_raw;
	} sample_t;

	typedef struct packed {
		logic signed [15:0] gyro_x;
		logic signed [15:0] gyro_y;
		logic signed [15:0] gyro_z;
		logic signed [15:0] accel_x;
		logic signed [15:0] accel_y;
		logic signed [15:0] accel_z;
		logic               calibrating;
	} result_t;

	// One ring row: all six channels of one sample, gyro x at index 0
	typedef logic [NCH-1:0][DATA_W-1:0] row_t;

endpackage

`default_nettype wire

FILE: hw/rtl/six_axis_moving_average_bias_cal_unit.sv
// Path: an accepted sample passes registers s1, s2, s3 and s4, then the output register.
// Throughput: one transaction per cycle unless the output stalls or the bias divider is busy;
// a calibrate command takes a pipeline slot but gives no result. After the last calibration
// sample the divider holds the final stage to form the new biases (one multiply, one negate).
// Reset: ring row valid bits, running sums, biases and calibration state clear at once;
// rows never written read as zero, so no clearing pass is needed.
`default_nettype none

module six_axis_moving_average_bias_cal_unit import smabc_pkg::*; #(
	parameter int WINDOW         = WINDOW_DEF,
	parameter int CAL_SAMPLES    = CAL_SAMPLES_DEF,
	parameter int SETTLE_SAMPLES = SETTLE_SAMPLES_DEF
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    sample_valid,
	output logic         sample_stall,
	input  wire sample_t sample,
	output logic         result_valid,
	input  wire logic    result_stall,
	output result_t      result
);

	// Window sizing and exact reciprocal for the truncating window mean
	localparam int SLOT_W    = $clog2(WINDOW);
	localparam int SUM_W     = DATA_W + $clog2(WINDOW);
	localparam int WIN_SH    = SUM_W + $clog2(WINDOW);
	localparam int WIN_RCP_W = SUM_W + 1;
	localparam int WIN_PRD_W = 2 * SUM_W + 1;
	localparam logic [WIN_RCP_W-1:0] WIN_RCP =
		WIN_RCP_W'(((64'd1 << WIN_SH) + 64'(WINDOW) - 64'd1) / 64'(WINDOW));
	localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(WINDOW - 1);

	// Calibration sizing and exact reciprocal for the bias mean
	localparam int ACC_W     = DATA_W + $clog2(CAL_SAMPLES);
	localparam int CAL_SH    = ACC_W + $clog2(CAL_SAMPLES);
	localparam int CAL_RCP_W = ACC_W + 1;
	localparam int CAL_PRD_W = 2 * ACC_W + 1;
	localparam logic [CAL_RCP_W-1:0] CAL_RCP =
		CAL_RCP_W'(((64'd1 << CAL_SH) + 64'(CAL_SAMPLES) - 64'd1) / 64'(CAL_SAMPLES));
	localparam int CNT_W = $clog2(SETTLE_SAMPLES + CAL_SAMPLES + 1);
	localparam logic [CNT_W-1:0] SETTLE_CNT = CNT_W'(SETTLE_SAMPLES);
	localparam logic [CNT_W-1:0] LAST_CNT   = CNT_W'(SETTLE_SAMPLES + CAL_SAMPLES - 1);

	// Sample ring memory and per-row valid bits
	row_t              ring_mem [WINDOW];
	logic [WINDOW-1:0] row_vld_q;
	logic [SLOT_W-1:0] slot_q;

	// Pipeline registers
	logic                    v_s1, v_s2, v_s3, v_s4;
	logic                    cmd_s1, cmd_s2, cmd_s3, cmd_s4;
	row_t                    new_s1, old_s1;
	logic                    oldv_s1;
	logic signed [SUM_W-1:0] sum_q  [NCH];
	logic signed [SUM_W-1:0] sum_s2 [NCH];
	logic [WIN_PRD_W-1:0]    prod_s3 [NCH];
	logic [NCH-1:0]          neg_s3;
	logic [DATA_W-1:0]       mean_s4 [NCH];

	// Calibration state and bias divider
	logic [DATA_W-1:0]       bias_q [NGYRO];
	logic signed [ACC_W-1:0] acc_q  [NGYRO];
	logic [CNT_W-1:0]        cnt_q;
	logic                    cal_active_q;
	logic                    dv1_q, dv2_q;
	logic [ACC_W-1:0]        dmag_q [NGYRO];
	logic [NGYRO-1:0]        dneg_q;
	logic [CAL_PRD_W-1:0]    dprod_q [NGYRO];

	// Output register
	result_t result_q;
	logic    result_valid_q;

	// Flow control
	logic accept, take_out, busy;
	logic go1, go2, go3, go4;
	logic free1, free2, free3, free4;
	row_t new_row;

	// Combinational values
	logic signed [SUM_W-1:0] sum_nx [NCH];
	logic [SUM_W-1:0]        mag [NCH];
	logic [DATA_W-1:0]       q_win [NCH];
	logic [DATA_W-1:0]       gout [NGYRO];
	logic signed [ACC_W-1:0] acc_nx [NGYRO];
	logic [DATA_W-1:0]       q_cal [NGYRO];
	logic                    cal_take, cal_last;

	assign new_row = {sample.accel_z_raw, sample.accel_y_raw, sample.accel_x_raw,
		sample.gyro_z_raw, sample.gyro_y_raw, sample.gyro_x_raw};

	// Advance a stage when its successor is empty or moving; the last stage also waits while the bias divider is busy
	assign take_out     = !result_valid_q || !result_stall;
	assign busy         = dv1_q || dv2_q;
	assign go4          = v_s4 && !busy && (cmd_s4 || take_out);
	assign free4        = !v_s4 || go4;
	assign go3          = v_s3 && free4;
	assign free3        = !v_s3 || go3;
	assign go2          = v_s2 && free3;
	assign free2        = !v_s2 || go2;
	assign go1          = v_s1 && free2;
	assign free1        = !v_s1 || go1;
	assign sample_stall = !free1;
	assign accept       = sample_valid && !sample_stall;

	assign result_valid = result_valid_q;
	assign result       = result_q;

	// Read old row and write new row at the same slot; read returns the old contents
	always_ff @(posedge clk) begin
		if (accept && sample.func == FUNC_SAMPLE) begin
			ring_mem[slot_q] <= new_row;
			old_s1           <= ring_mem[slot_q];
		end
	end

	// Running sum update: add the new sample, drop the one it replaces
	always_comb begin
		logic [DATA_W-1:0] oldv;
		for (int c = 0; c < NCH; c++) begin
			oldv = oldv_s1 ? old_s1[c] : '0;
			sum_nx[c] = sum_q[c]
				+ $signed({{(SUM_W-DATA_W){new_s1[c][DATA_W-1]}}, new_s1[c]})
				- $signed({{(SUM_W-DATA_W){oldv[DATA_W-1]}}, oldv});
		end
	end

	// Magnitude for the reciprocal multiply, and quotient after it
	always_comb begin
		for (int c = 0; c < NCH; c++) begin
			mag[c]   = sum_s2[c][SUM_W-1] ? SUM_W'(-sum_s2[c]) : SUM_W'(sum_s2[c]);
			q_win[c] = prod_s3[c][WIN_SH +: DATA_W];
		end
	end

	// Subtract bias and saturate gyro means; accumulate during calibration
	always_comb begin
		logic signed [DATA_W:0] diff;
		for (int g = 0; g < NGYRO; g++) begin
			diff = $signed({mean_s4[g][DATA_W-1], mean_s4[g]})
				- $signed({bias_q[g][DATA_W-1], bias_q[g]});
			if (diff[DATA_W] != diff[DATA_W-1]) begin
				gout[g] = diff[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}}
					: {1'b0, {(DATA_W-1){1'b1}}};
			end else begin
				gout[g] = diff[DATA_W-1:0];
			end
			acc_nx[g] = acc_q[g]
				+ $signed({{(ACC_W-DATA_W){gout[g][DATA_W-1]}}, gout[g]});
			q_cal[g] = dprod_q[g][CAL_SH +: DATA_W];
		end
	end

	assign cal_take = cal_active_q && (cnt_q >= SETTLE_CNT);
	assign cal_last = cal_active_q && (cnt_q == LAST_CNT);

	// Control state: slot, row valid bits, stage valids, running sums, output valid, calibration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q         <= '0;
			row_vld_q      <= '0;
			v_s1           <= 1'b0;
			v_s2           <= 1'b0;
			v_s3           <= 1'b0;
			v_s4           <= 1'b0;
			result_valid_q <= 1'b0;
			cal_active_q   <= 1'b0;
			cnt_q          <= '0;
			dv1_q          <= 1'b0;
			dv2_q          <= 1'b0;
			for (int c = 0; c < NCH; c++) begin
				sum_q[c] <= '0;
			end
			for (int g = 0; g < NGYRO; g++) begin
				bias_q[g] <= '0;
				acc_q[g]  <= '0;
			end
		end else begin
			// advance the ring slot on each accepted sample
			if (accept && sample.func == FUNC_SAMPLE) begin
				row_vld_q[slot_q] <= 1'b1;
				slot_q            <= (slot_q == SLOT_LAST) ? '0 : slot_q + 1'b1;
			end

			// stage valids
			if (accept) v_s1 <= 1'b1;
			else if (go1) v_s1 <= 1'b0;
			if (go1) v_s2 <= 1'b1;
			else if (go2) v_s2 <= 1'b0;
			if (go2) v_s3 <= 1'b1;
			else if (go3) v_s3 <= 1'b0;
			if (go3) v_s4 <= 1'b1;
			else if (go4) v_s4 <= 1'b0;

			// commit running sums as a sample leaves stage 1
			if (go1 && !cmd_s1) begin
				for (int c = 0; c < NCH; c++) begin
					sum_q[c] <= sum_nx[c];
				end
			end

			// output valid
			if (go4 && !cmd_s4) result_valid_q <= 1'b1;
			else if (!result_stall) result_valid_q <= 1'b0;

			// bias divider sequencing: start on the last calibration sample
			dv1_q <= go4 && !cmd_s4 && cal_last;
			dv2_q <= dv1_q;
			if (dv2_q) begin
				for (int g = 0; g < NGYRO; g++) begin
					bias_q[g] <= dneg_q[g] ? DATA_W'(-q_cal[g]) : q_cal[g];
				end
			end

			// calibration command and sample bookkeeping
			if (go4) begin
				if (cmd_s4) begin
					cal_active_q <= 1'b1;
					cnt_q        <= '0;
					for (int g = 0; g < NGYRO; g++) begin
						bias_q[g] <= '0;
						acc_q[g]  <= '0;
					end
				end else if (cal_active_q) begin
					if (cal_take) begin
						for (int g = 0; g < NGYRO; g++) begin
							acc_q[g] <= acc_nx[g];
						end
					end
					if (cal_last) begin
						cal_active_q <= 1'b0;
						cnt_q        <= '0;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
			end
		end
	end

	// Datapath registers: load as a transaction enters each stage
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1  <= (sample.func == FUNC_CAL);
			new_s1  <= new_row;
			oldv_s1 <= row_vld_q[slot_q];
		end
		if (go1) begin
			cmd_s2 <= cmd_s1;
			for (int c = 0; c < NCH; c++) begin
				sum_s2[c] <= sum_nx[c];
			end
		end
		if (go2) begin
			cmd_s3 <= cmd_s2;
			for (int c = 0; c < NCH; c++) begin
				prod_s3[c] <= WIN_PRD_W'(mag[c]) * WIN_PRD_W'(WIN_RCP);
				neg_s3[c]  <= sum_s2[c][SUM_W-1];
			end
		end
		if (go3) begin
			cmd_s4 <= cmd_s3;
			for (int c = 0; c < NCH; c++) begin
				mean_s4[c] <= neg_s3[c] ? DATA_W'(-q_win[c]) : q_win[c];
			end
		end

		// capture final accumulator, then multiply by the reciprocal
		if (go4 && !cmd_s4 && cal_last) begin
			for (int g = 0; g < NGYRO; g++) begin
				dneg_q[g] <= acc_nx[g][ACC_W-1];
				dmag_q[g] <= acc_nx[g][ACC_W-1] ? ACC_W'(-acc_nx[g]) : ACC_W'(acc_nx[g]);
			end
		end
		if (dv1_q) begin
			for (int g = 0; g < NGYRO; g++) begin
				dprod_q[g] <= CAL_PRD_W'(dmag_q[g]) * CAL_PRD_W'(CAL_RCP);
			end
		end

		// result payload
		if (go4 && !cmd_s4) begin
			result_q.gyro_x      <= gout[0];
			result_q.gyro_y      <= gout[1];
			result_q.gyro_z      <= gout[2];
			result_q.accel_x     <= mean_s4[3];
			result_q.accel_y     <= mean_s4[4];
			result_q.accel_z     <= mean_s4[5];
			result_q.calibrating <= cal_active_q;
		end
	end

endmodule

`default_nettype wire

FILE: test/six_axis_moving_average_bias_cal_unit_checker.sv
// Checker for the six-axis moving-average filter with gyro bias calibration.
// Watches both channels, predicts each result from the accepted samples and compares it.
// Depends on smabc_pkg for the transaction structs, command codes and default sizes.
`default_nettype none

module six_axis_moving_average_bias_cal_unit_checker import smabc_pkg::*; #(
	parameter int WINDOW         = WINDOW_DEF,
	parameter int CAL_SAMPLES    = CAL_SAMPLES_DEF,
	parameter int SETTLE_SAMPLES = SETTLE_SAMPLES_DEF
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    sample_valid,
	input  wire logic    sample_stall,
	input  wire sample_t sample,
	input  wire logic    result_valid,
	input  wire logic    result_stall,
	input  wire result_t result,
	output int           n_mismatch,
	output int           n_waiting,
	output int           n_checked,
	output int           n_cal_cmds,
	output int           n_cal_done,
	output int           n_clipped,
	output int           n_held
);
	timeunit 1ns;
	timeprecision 1ps;

	// Filter state: one ring and one running sum per channel
	int ring_mem [NCH][WINDOW];
	int win_sum [NCH];
	int slot;

	// Calibration state
	int gyro_offset [NGYRO];
	int offset_acc [NGYRO];
	int cal_count;
	bit cal_on;

	result_t expected_means[$];

	int mismatches = 0;
	int waiting    = 0;
	int checked    = 0;
	int cal_cmds   = 0;
	int cal_done   = 0;
	int clipped    = 0;
	int held       = 0;

	assign n_mismatch = mismatches;
	assign n_waiting  = waiting;
	assign n_checked  = checked;
	assign n_cal_cmds = cal_cmds;
	assign n_cal_done = cal_done;
	assign n_clipped  = clipped;
	assign n_held     = held;

	task automatic flag_mismatch(input string msg);
		$display("[%0t] MISMATCH: %s", $realtime, msg);
		mismatches++;
	endtask

	// Advance the predicted filter by one transaction; queue its output if it makes one
	task automatic filter_step(input sample_t s);
		int raw [NCH];
		int avg [NCH];
		bit in_cal;
		result_t r;
		if (s.func == FUNC_CAL) begin
			for (int c = 0; c < NGYRO; c++) begin
				gyro_offset[c] = 0;
				offset_acc[c]  = 0;
			end
			cal_count = 0;
			cal_on    = 1'b1;
			cal_cmds++;
			return;
		end
		raw[0] = s.gyro_x_raw;
		raw[1] = s.gyro_y_raw;
		raw[2] = s.gyro_z_raw;
		raw[3] = s.accel_x_raw;
		raw[4] = s.accel_y_raw;
		raw[5] = s.accel_z_raw;

		// Swap the oldest entry for the new one and take the truncated mean
		for (int c = 0; c < NCH; c++) begin
			win_sum[c] += raw[c] - ring_mem[c][slot];
			ring_mem[c][slot] = raw[c];
			avg[c] = win_sum[c] / WINDOW;
		end
		slot = (slot + 1) % WINDOW;

		// Remove the gyro bias and clip to 16 bits
		for (int c = 0; c < NGYRO; c++) begin
			avg[c] -= gyro_offset[c];
			if (avg[c] > 32767) begin
				avg[c] = 32767;
				clipped++;
			end else if (avg[c] < -32768) begin
				avg[c] = -32768;
				clipped++;
			end
		end

		// Skip the settling samples, then accumulate; close the calibration on the last one
		in_cal = cal_on;
		if (cal_on) begin
			if (cal_count >= SETTLE_SAMPLES) begin
				for (int c = 0; c < NGYRO; c++)
					offset_acc[c] += avg[c];
			end
			if (cal_count + 1 >= SETTLE_SAMPLES + CAL_SAMPLES) begin
				for (int c = 0; c < NGYRO; c++)
					gyro_offset[c] = offset_acc[c] / CAL_SAMPLES;
				cal_on    = 1'b0;
				cal_count = 0;
				cal_done++;
			end else begin
				cal_count++;
			end
		end

		r.gyro_x      = 16'(avg[0]);
		r.gyro_y      = 16'(avg[1]);
		r.gyro_z      = 16'(avg[2]);
		r.accel_x     = 16'(avg[3]);
		r.accel_y     = 16'(avg[4]);
		r.accel_z     = 16'(avg[5]);
		r.calibrating = in_cal;
		expected_means.push_back(r);
	endtask

	task automatic check_lane(input string name, input logic signed [15:0] got,
			input logic signed [15:0] want);
		if (got !== want)
			flag_mismatch($sformatf("result %0d %s: got %0d, expected %0d",
				checked, name, got, want));
	endtask

	task automatic compare_result(input result_t got);
		result_t want;
		if (expected_means.size() == 0) begin
			flag_mismatch("result with no sample waiting for it");
			return;
		end
		want = expected_means.pop_front();
		check_lane("gyro_x", got.gyro_x, want.gyro_x);
		check_lane("gyro_y", got.gyro_y, want.gyro_y);
		check_lane("gyro_z", got.gyro_z, want.gyro_z);
		check_lane("accel_x", got.accel_x, want.accel_x);
		check_lane("accel_y", got.accel_y, want.accel_y);
		check_lane("accel_z", got.accel_z, want.accel_z);
		if (got.calibrating !== want.calibrating)
			flag_mismatch($sformatf("result %0d calibrating: got %b, expected %b",
				checked, got.calibrating, want.calibrating));
		checked++;
	endtask

	// Sample both channels at the clock edge; clear the prediction on reset
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < NCH; c++) begin
				win_sum[c] = 0;
				for (int k = 0; k < WINDOW; k++)
					ring_mem[c][k] = 0;
			end
			for (int c = 0; c < NGYRO; c++) begin
				gyro_offset[c] = 0;
				offset_acc[c]  = 0;
			end
			slot      = 0;
			cal_count = 0;
			cal_on    = 1'b0;
			expected_means.delete();
		end else begin
			if (result_valid && !result_stall)
				compare_result(result);
			if (sample_valid && !sample_stall)
				filter_step(sample);
			if (sample_valid && sample_stall)
				held++;
		end
		waiting = expected_means.size();
	end

endmodule

`default_nettype wire

FILE: test/six_axis_moving_average_bias_cal_unit_tb.sv
// Testbench top for the six-axis moving-average filter with gyro bias calibration.
// Drives samples and calibrate commands with random gaps and stalls; the checker module
// predicts and compares. Depends on smabc_pkg, the block and its checker.
`default_nettype none

module six_axis_moving_average_bias_cal_unit_tb import smabc_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WINDOW         = WINDOW_DEF;
	localparam int CAL_SAMPLES    = CAL_SAMPLES_DEF;
	localparam int SETTLE_SAMPLES = SETTLE_SAMPLES_DEF;

	localparam int TARGET_ITEMS = 1800;
	localparam int LONG_HOLD    = 250;
	localparam int DRAIN_CYCLES = 20;

	logic    clk = 1'b0;
	logic    arst_n;
	logic    sample_valid;
	logic    sample_stall;
	sample_t sample;
	logic    result_valid;
	logic    result_stall;
	result_t result;

	int n_mismatch, n_waiting, n_checked, n_cal_cmds, n_cal_done, n_clipped, n_held;

	int items_sent = 0;
	bit src_fast   = 1'b0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	six_axis_moving_average_bias_cal_unit #(
		.WINDOW        (WINDOW),
		.CAL_SAMPLES   (CAL_SAMPLES),
		.SETTLE_SAMPLES(SETTLE_SAMPLES)
	) u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.sample_valid(sample_valid),
		.sample_stall(sample_stall),
		.sample      (sample),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result      (result)
	);

	six_axis_moving_average_bias_cal_unit_checker #(
		.WINDOW        (WINDOW),
		.CAL_SAMPLES   (CAL_SAMPLES),
		.SETTLE_SAMPLES(SETTLE_SAMPLES)
	) u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.sample_valid(sample_valid),
		.sample_stall(sample_stall),
		.sample      (sample),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result      (result),
		.n_mismatch  (n_mismatch),
		.n_waiting   (n_waiting),
		.n_checked   (n_checked),
		.n_cal_cmds  (n_cal_cmds),
		.n_cal_done  (n_cal_done),
		.n_clipped   (n_clipped),
		.n_held      (n_held)
	);

	// Reading near a center value, clipped to the 16-bit range
	function automatic logic [15:0] near(input int center);
		int v;
		v = center + int'($urandom_range(0, 64)) - 32;
		if (v > 32767)
			v = 32767;
		if (v < -32768)
			v = -32768;
		return 16'(v);
	endfunction

	// Center for a steady stretch: either rail half the time, else anywhere
	function automatic int pick_center();
		case ($urandom_range(0, 3))
			0: return 32767;
			1: return -32768;
			default: return int'($urandom_range(0, 65535)) - 32768;
		endcase
	endfunction

	function automatic sample_t sensor_reading(input bit steady, input int g_center,
			input int a_center);
		sample_t s;
		s.func        = FUNC_SAMPLE;
		s.gyro_x_raw  = steady ? near(g_center) : 16'($urandom);
		s.gyro_y_raw  = steady ? near(g_center) : 16'($urandom);
		s.gyro_z_raw  = steady ? near(g_center) : 16'($urandom);
		s.accel_x_raw = steady ? near(a_center) : 16'($urandom);
		s.accel_y_raw = steady ? near(a_center) : 16'($urandom);
		s.accel_z_raw = steady ? near(a_center) : 16'($urandom);
		return s;
	endfunction

	function automatic sample_t uniform_reading(input logic [15:0] v);
		sample_t s;
		s.func        = FUNC_SAMPLE;
		s.gyro_x_raw  = v;
		s.gyro_y_raw  = v;
		s.gyro_z_raw  = v;
		s.accel_x_raw = v;
		s.accel_y_raw = v;
		s.accel_z_raw = v;
		return s;
	endfunction

	// Calibrate command; the sample fields carry noise that the block must ignore
	function automatic sample_t calibrate_cmd();
		sample_t s;
		s      = sensor_reading(1'b0, 0, 0);
		s.func = FUNC_CAL;
		return s;
	endfunction

	// Offer one transaction after a random gap and hold it until accepted
	task automatic push_sample(input sample_t s);
		int gap;
		gap = src_fast ? 0 : $urandom_range(0, 9);
		if (gap > 0) begin
			sample_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sample_valid <= 1'b1;
		sample       <= s;
		do
			@(posedge clk);
		while (sample_stall !== 1'b0);
		items_sent++;
	endtask

	// Result side: draw a stall per transaction, with calm stretches and two long holds
	initial begin : drain_results
		int hold;
		int taken;
		bit calm;
		hold  = 0;
		taken = 0;
		calm  = 1'b0;
		result_stall <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (result_valid && !result_stall) begin
				taken++;
				if (taken % 64 == 0)
					calm = ($urandom_range(0, 2) == 0);
				if (taken == 300 || taken == 1000)
					hold = LONG_HOLD;
				else
					hold = calm ? 0 : $urandom_range(0, 9);
			end
			if (hold > 0) begin
				result_stall <= 1'b1;
				hold--;
			end else begin
				result_stall <= 1'b0;
			end
		end
	end

	// Stimulus and verdict
	initial begin : stimulus
		int seg;
		bit steady;
		int g_center;
		int a_center;
		arst_n       <= 1'b0;
		sample_valid <= 1'b0;
		sample       <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: rails with the reset zeros still in the window, calibrate and a
		// restart of it, ignored payload, truncation of small negatives, bit patterns
		repeat (3) push_sample(uniform_reading(16'h7FFF));
		push_sample(calibrate_cmd());
		repeat (2) push_sample(uniform_reading(16'h8000));
		push_sample(calibrate_cmd());
		push_sample(uniform_reading(-16'sd7));
		push_sample(uniform_reading(-16'sd13));
		push_sample(uniform_reading(-16'sd1));
		push_sample(uniform_reading(16'h5555));
		push_sample(uniform_reading(16'hAAAA));
		repeat (WINDOW) push_sample(uniform_reading(16'h8000));
		push_sample(uniform_reading(16'h7FFF));

		// Random: mostly bursts, plus full calibrations (mostly with steady content) and cut-short ones
		while (items_sent < TARGET_ITEMS) begin
			seg      = $urandom_range(0, 9);
			src_fast = ($urandom_range(0, 3) == 0);
			g_center = pick_center();
			a_center = pick_center();
			if (seg < 3) begin
				steady = ($urandom_range(0, 3) != 0);
				push_sample(calibrate_cmd());
				repeat (SETTLE_SAMPLES + CAL_SAMPLES)
					push_sample(sensor_reading(steady, g_center, a_center));
			end else if (seg == 3) begin
				push_sample(calibrate_cmd());
				repeat ($urandom_range(1, 150))
					push_sample(sensor_reading(1'b0, 0, 0));
			end else begin
				steady = $urandom_range(0, 1);
				repeat ($urandom_range(10, 60))
					push_sample(sensor_reading(steady, g_center, a_center));
			end
		end
		sample_valid <= 1'b0;

		// Drain: wait for every expected result, then let the clock run on before the verdict
		do
			@(negedge clk);
		while (n_waiting != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d transactions: %0d calibrate commands, %0d results checked",
			items_sent, n_cal_cmds, n_checked);
		$display("%0d calibrations completed, %0d gyro outputs clipped, input held %0d cycles",
			n_cal_done, n_clipped, n_held);
		if (n_mismatch == 0)
			$display("six_axis_moving_average_bias_cal_unit_tb: done, clean");
		else
			$display("six_axis_moving_average_bias_cal_unit_tb: done, errors");
		$finish;
	end

	// Watchdog
	initial begin : watchdog
		#2_000_000;
		$display("timeout with %0d results outstanding", n_waiting);
		$display("six_axis_moving_average_bias_cal_unit_tb: done, errors");
		$finish;
	end

endmodule

`default_nettype wire
